@@ src/fbsa_pkg.sv @@
// Shared constants, status codes and controller/datapath interface types for the slot allocator.
package fbsa_pkg;

    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;
    localparam int PAIR         = 2;

    localparam logic [11:0] RANK_MAX = 12'd4095;

    // Result status codes
    localparam logic [2:0] STAT_PLACED    = 3'd0;
    localparam logic [2:0] STAT_REFUSED   = 3'd1;
    localparam logic [2:0] STAT_TRUNCATED = 3'd2;
    localparam logic [2:0] STAT_FULL      = 3'd3;
    localparam logic [2:0] STAT_RESTART   = 3'd4;

    // Request types
    localparam logic REQ_RESTART  = 1'b0;
    localparam logic REQ_ALLOCATE = 1'b1;

    // Configuration register indexes
    localparam logic [3:0] REG_FRAME_ROWS = 4'd0;
    localparam logic [3:0] REG_FRAME_COLS = 4'd1;

    typedef struct packed {
        logic accept;
        logic eval;
        logic walk;
        logic settle;
        logic load_out;
    } fbsa_cmd_t;

    typedef struct packed {
        logic place;
        logic walk_last;
        logic out_free;
    } fbsa_sts_t;

endpackage

@@ src/frame_burst_slot_allocator.sv @@
// Restart, refused and frame-full requests go from EVAL straight to DONE; a placing burst walks
// one column per WALK step (plus an empty step unless it ends leaving the top pair), then SETTLE.
// One request in flight; the next is taken the cycle after its result is loaded, and a held
// result stalls input.
// Reset: synchronous, active low; frame returns to 16x16, cursor at the bottom row pair,
// column 0, rank 1, budget 256, no result pending.
module frame_burst_slot_allocator #(
    parameter int MAX_ROWS = fbsa_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = fbsa_pkg::MAX_COLS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [6:0]         cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic [12:0]        s_burst_size,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [11:0]        m_burst_rank,
    output logic [5:0]         m_start_row,
    output logic [5:0]         m_start_col,
    output logic [12:0]        m_slots_placed,
    output logic signed [6:0]  m_cursor_row_after,
    output logic [5:0]         m_cursor_col_after,
    output logic signed [13:0] m_slots_remaining,
    output logic [12:0]        m_unused_slots
);
    import fbsa_pkg::*;

    fbsa_cmd_t cmd;
    fbsa_sts_t sts;

    assign cfg_ready = 1'b1;

    fbsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    fbsa_dpath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dpath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_req_type         (s_req_type),
        .s_burst_size       (s_burst_size),
        .cmd                (cmd),
        .sts                (sts),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_burst_rank       (m_burst_rank),
        .m_start_row        (m_start_row),
        .m_start_col        (m_start_col),
        .m_slots_placed     (m_slots_placed),
        .m_cursor_row_after (m_cursor_row_after),
        .m_cursor_col_after (m_cursor_col_after),
        .m_slots_remaining  (m_slots_remaining),
        .m_unused_slots     (m_unused_slots)
    );

`ifndef NO_ASSERTIONS
    // one request at a time: no second acceptance straight after the first
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while one is in flight");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STAT_PLACED) || (m_status == STAT_REFUSED)
            || (m_status == STAT_TRUNCATED) || (m_status == STAT_FULL)
            || (m_status == STAT_RESTART))
        else $error("undefined status code");

    // only placing outcomes carry a rank or placed slots
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STAT_PLACED) && (m_status != STAT_TRUNCATED)
            |-> (m_burst_rank == 12'd0) && (m_slots_placed == 13'd0))
        else $error("rank or slots reported without placement");

    // a truncated burst always placed something
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STAT_TRUNCATED) |-> (m_slots_placed != 13'd0))
        else $error("truncated burst with no slots placed");
`endif

endmodule

@@ src/fbsa_ctrl.sv @@
// Sequencing state machine for the slot allocator.
module fbsa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  fbsa_pkg::fbsa_sts_t sts,
    output fbsa_pkg::fbsa_cmd_t cmd
);
    import fbsa_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EVAL   = 5'b00010,
        ST_WALK   = 5'b00100,
        ST_SETTLE = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = sts.place ? ST_WALK : ST_DONE;
            end
            ST_WALK: begin
                cmd.walk = 1'b1;
                if (sts.walk_last) begin
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE: begin
                cmd.settle = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/fbsa_dpath.sv @@
// Frame state, cursor walk, budget accounting and result register for the slot allocator.
module fbsa_dpath #(
    parameter int MAX_ROWS = fbsa_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = fbsa_pkg::MAX_COLS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic [3:0]         cfg_index,
    input  logic [6:0]         cfg_data,
    input  logic               s_req_type,
    input  logic [12:0]        s_burst_size,
    input  fbsa_pkg::fbsa_cmd_t cmd,
    output fbsa_pkg::fbsa_sts_t sts,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [11:0]        m_burst_rank,
    output logic [5:0]         m_start_row,
    output logic [5:0]         m_start_col,
    output logic [12:0]        m_slots_placed,
    output logic signed [6:0]  m_cursor_row_after,
    output logic [5:0]         m_cursor_col_after,
    output logic signed [13:0] m_slots_remaining,
    output logic [12:0]        m_unused_slots
);
    import fbsa_pkg::*;

    // config data is 7 bits wide, so the usable limits stop at 127
    localparam int ROWS_CAP = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
    localparam int COLS_CAP = (MAX_COLS > 127) ? 127 : MAX_COLS;
    localparam int AREA_W   = $clog2(ROWS_CAP * COLS_CAP + 1);
    localparam int BUD_W    = AREA_W + 2;
    localparam int CMP_W    = (BUD_W > 14) ? BUD_W : 14;

    logic [6:0]              rows_reg, rows_next;
    logic [6:0]              cols_reg, cols_next;
    logic [AREA_W-1:0]       area_reg;
    logic signed [7:0]       row_reg, row_next;
    logic [6:0]              col_reg, col_next;
    logic signed [BUD_W-1:0] budget_reg, budget_next;
    logic [11:0]             rank_reg, rank_next;
    logic [AREA_W-1:0]       written_reg, written_next;
    logic                    req_reg;
    logic [12:0]             left_reg, left_next;
    logic [11:0]             myrank_reg, myrank_next;
    logic [12:0]             placed_reg, placed_next;
    logic [5:0]              srow_reg, srow_next;
    logic [5:0]              scol_reg, scol_next;
    logic [2:0]              stat_reg, stat_next;
    logic [11:0]             orank_reg, orank_next;
    logic                    m_valid_reg;

    logic [2:0]              m_status_reg;
    logic [11:0]             m_rank_reg;
    logic [5:0]              m_srow_reg, m_scol_reg;
    logic [12:0]             m_placed_reg;
    logic signed [6:0]       m_row_reg;
    logic [5:0]              m_col_reg;
    logic signed [13:0]      m_rem_reg;
    logic [12:0]             m_unused_reg;

    logic signed [CMP_W:0]   bud_x, size_x;
    logic signed [7:0]       jrow;
    logic [6:0]              jcol;
    logic                    take2, wrap, brk;
    logic [6:0]              col_inc;
    logic signed [7:0]       wrow;
    logic [12:0]             wleft;
    logic [13:0]             round_even;
    logic [AREA_W-1:0]       unused;

    // config writes, clamped into range
    always_comb begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_FRAME_ROWS: begin
                    if (cfg_data == 7'd0) begin
                        rows_next = 7'd1;
                    end else if (cfg_data > 7'(ROWS_CAP)) begin
                        rows_next = 7'(ROWS_CAP);
                    end else begin
                        rows_next = cfg_data;
                    end
                end
                REG_FRAME_COLS: begin
                    if (cfg_data < 7'd3) begin
                        cols_next = 7'd3;
                    end else if (cfg_data > 7'(COLS_CAP)) begin
                        cols_next = 7'(COLS_CAP);
                    end else begin
                        cols_next = cfg_data;
                    end
                end
                default: begin
                    rows_next = rows_reg;
                end
            endcase
        end
    end

    always_comb begin
        bud_x = (CMP_W + 1)'(budget_reg);
        size_x = (CMP_W + 1)'($signed({1'b0, left_reg}));

        // pre-jump of the cursor before a burst is placed
        jrow = row_reg;
        jcol = col_reg;
        if (col_reg >= cols_reg) begin
            jcol = 7'd0;
        end else if (col_reg == cols_reg - 7'(PAIR)) begin
            jcol = 7'd0;
            jrow = row_reg - 8'(PAIR);
        end

        // one column per walk step, two slots when the upper row exists and at least two are left
        take2   = (left_reg >= 13'd2) && (row_reg >= 8'sd1);
        wleft   = left_reg - (take2 ? 13'd2 : 13'd1);
        col_inc = col_reg + 7'd1;
        wrap    = (col_inc >= cols_reg);
        wrow    = wrap ? (row_reg - 8'(PAIR)) : row_reg;
        brk     = (wrow < 8'sd0);

        round_even = ({1'b0, placed_reg} + 14'd1) & ~14'd1;
        unused     = (area_reg > written_reg) ? (area_reg - written_reg) : '0;

        sts.place     = (req_reg == REQ_ALLOCATE) && !(bud_x < size_x) && (jrow >= 8'sd0);
        sts.walk_last = (left_reg == 13'd0) || brk;
        sts.out_free  = !m_valid_reg || m_ready;

        row_next     = row_reg;
        col_next     = col_reg;
        budget_next  = budget_reg;
        rank_next    = rank_reg;
        written_next = written_reg;
        left_next    = left_reg;
        myrank_next  = myrank_reg;
        placed_next  = placed_reg;
        srow_next    = srow_reg;
        scol_next    = scol_reg;
        stat_next    = stat_reg;
        orank_next   = orank_reg;

        if (cmd.accept) begin
            left_next = s_burst_size;
        end

        if (cmd.eval) begin
            placed_next = '0;
            srow_next   = '0;
            scol_next   = '0;
            orank_next  = '0;
            if (req_reg == REQ_RESTART) begin
                row_next     = $signed({1'b0, rows_reg}) - 8'sd1;
                col_next     = '0;
                budget_next  = $signed(BUD_W'(area_reg));
                rank_next    = 12'd1;
                written_next = '0;
                stat_next    = STAT_RESTART;
            end else if (bud_x < size_x) begin
                stat_next = STAT_REFUSED;
            end else begin
                myrank_next = rank_reg;
                if (rank_reg < RANK_MAX) begin
                    rank_next = rank_reg + 12'd1;
                end
                row_next  = jrow;
                col_next  = jcol;
                // a full frame reports no start position
                if (jrow >= 8'sd0) begin
                    srow_next = jrow[5:0];
                    scol_next = jcol[5:0];
                end
                stat_next = (jrow < 8'sd0) ? STAT_FULL : STAT_PLACED;
            end
        end

        if (cmd.walk) begin
            if (left_reg == 13'd0) begin
                stat_next = STAT_PLACED;
            end else begin
                left_next   = wleft;
                placed_next = placed_reg + (take2 ? 13'd2 : 13'd1);
                row_next    = wrow;
                col_next    = wrap ? 7'd0 : col_inc;
                if (brk) begin
                    stat_next = (wleft != 13'd0) ? STAT_TRUNCATED : STAT_PLACED;
                end
            end
        end

        if (cmd.settle) begin
            budget_next  = budget_reg - $signed(BUD_W'(round_even));
            written_next = written_reg + AREA_W'(placed_reg);
            orank_next   = (placed_reg != 13'd0) ? myrank_reg : 12'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg    <= 7'd16;
            cols_reg    <= 7'd16;
            row_reg     <= 8'sd15;
            col_reg     <= '0;
            budget_reg  <= BUD_W'(256);
            rank_reg    <= 12'd1;
            written_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            rows_reg    <= rows_next;
            cols_reg    <= cols_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            budget_reg  <= budget_next;
            rank_reg    <= rank_next;
            written_reg <= written_next;
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        area_reg   <= AREA_W'(rows_reg) * AREA_W'(cols_reg);
        left_reg   <= left_next;
        myrank_reg <= myrank_next;
        placed_reg <= placed_next;
        srow_reg   <= srow_next;
        scol_reg   <= scol_next;
        stat_reg   <= stat_next;
        orank_reg  <= orank_next;
        if (cmd.accept) begin
            req_reg <= s_req_type;
        end
        if (cmd.load_out) begin
            m_status_reg <= stat_reg;
            m_rank_reg   <= orank_reg;
            m_srow_reg   <= srow_reg;
            m_scol_reg   <= scol_reg;
            m_placed_reg <= placed_reg;
            m_row_reg    <= row_reg[6:0];
            m_col_reg    <= col_reg[5:0];
            m_rem_reg    <= 14'(budget_reg);
            m_unused_reg <= 13'(unused);
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_burst_rank       = m_rank_reg;
    assign m_start_row        = m_srow_reg;
    assign m_start_col        = m_scol_reg;
    assign m_slots_placed     = m_placed_reg;
    assign m_cursor_row_after = m_row_reg;
    assign m_cursor_col_after = m_col_reg;
    assign m_slots_remaining  = m_rem_reg;
    assign m_unused_slots     = m_unused_reg;

endmodule
